// ===== rtl/gibr_pkg.sv =====
// Package: types and constants shared by the bilinear scaler files.
package gibr_pkg;

  localparam int SrcMax    = 256;
  localparam int DstMax    = 1024;
  localparam int FracBits  = 8;
  localparam int SrcAw     = 8;
  localparam int ProdW     = 18;
  localparam int NumSteps  = ProdW + FracBits;
  localparam int WrDelay   = NumSteps + 2;

  localparam logic [1:0] RegSrcW = 2'd0;
  localparam logic [1:0] RegSrcH = 2'd1;
  localparam logic [1:0] RegDstW = 2'd2;
  localparam logic [1:0] RegDstH = 2'd3;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       out_of_range;
  } out_item_t;

endpackage

// ===== rtl/gibr_div.sv =====
// Module: pipelined restoring divider, one quotient bit per stage.
module gibr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [gibr_pkg::NumSteps-1:0] in_num,
  input  logic [10:0]                   in_den,
  input  logic [19:0]                   in_tag,
  output logic                          out_vld,
  output logic [gibr_pkg::NumSteps-1:0] out_quo,
  output logic [19:0]                   out_tag
);
  localparam int N = gibr_pkg::NumSteps;

  // Stage registers: entry i holds the state after i quotient bits
  logic             vld_r [1:N];
  logic [N-1:0]     num_r [1:N];
  logic [10:0]      den_r [1:N];
  logic [11:0]      rem_r [1:N];
  logic [19:0]      tag_r [1:N];

  // One quotient bit per stage, shifting the numerator through
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic         vld_in;
    logic [N-1:0] num_in;
    logic [10:0]  den_in;
    logic [11:0]  rem_in;
    logic [19:0]  tag_in;
    logic [12:0]  trial;
    logic [11:0]  rem_nxt;
    logic [N-1:0] num_nxt;
    if (i == 0) begin : g_head
      assign vld_in = in_vld;
      assign num_in = in_num;
      assign den_in = in_den;
      assign rem_in = '0;
      assign tag_in = in_tag;
    end else begin : g_body
      assign vld_in = vld_r[i];
      assign num_in = num_r[i];
      assign den_in = den_r[i];
      assign rem_in = rem_r[i];
      assign tag_in = tag_r[i];
    end
    always_comb begin
      trial   = {rem_in, num_in[N-1]} - {2'b00, den_in};
      rem_nxt = trial[12] ? {rem_in[10:0], num_in[N-1]} : trial[11:0];
      num_nxt = {num_in[N-2:0], ~trial[12]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_in;
      num_r[i+1] <= num_nxt;
      den_r[i+1] <= den_in;
      rem_r[i+1] <= rem_nxt;
      tag_r[i+1] <= tag_in;
    end
  end

  assign out_vld = vld_r[N];
  assign out_quo = num_r[N];
  assign out_tag = tag_r[N];
endmodule

// ===== rtl/gray_image_bilinear_resize_core.sv =====
// Module: top level of the bilinear grayscale scaler.
// Read path: a multiply stage, the 26-stage divider, then neighbour coordinate,
// bank read, horizontal blend and vertical blend/output stages.
// Throughput: one command per cycle; writes pass a delay line so they reach
// the four frame store banks (even/odd column and row) in command order.
// Reset: sizes return to 256, pipeline empties; frame contents stay undefined.
// Results are strobed for one cycle; the receiver cannot stall.
module gray_image_bilinear_resize_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gibr_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output gibr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [10:0]         cfg_data
);
  localparam int PW = gibr_pkg::ProdW;
  localparam int WD = gibr_pkg::WrDelay;

  logic [8:0]  src_w_r, src_h_r;
  logic [10:0] dst_w_r, dst_h_r;
  logic [8:0]  sw, sh;
  logic [10:0] dw, dh;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256; src_h_r <= 9'd256;
      dst_w_r <= 11'd256; dst_h_r <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gibr_pkg::RegSrcW: src_w_r <= cfg_data[8:0];
        gibr_pkg::RegSrcH: src_h_r <= cfg_data[8:0];
        gibr_pkg::RegDstW: dst_w_r <= cfg_data;
        gibr_pkg::RegDstH: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped sizes
  always_comb begin
    sw = (src_w_r == 9'd0) ? 9'd1 : (src_w_r > 9'd256) ? 9'd256 : src_w_r;
    sh = (src_h_r == 9'd0) ? 9'd1 : (src_h_r > 9'd256) ? 9'd256 : src_h_r;
    dw = (dst_w_r == 11'd0) ? 11'd1 : (dst_w_r > 11'd1024) ? 11'd1024 : dst_w_r;
    dh = (dst_h_r == 11'd0) ? 11'd1 : (dst_h_r > 11'd1024) ? 11'd1024 : dst_h_r;
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start;

  // Frame store: four banks by column and row parity
  logic [7:0] bank [4][16384];
  logic       wr_ok;
  logic [1:0] wr_bank;
  logic [13:0] wr_addr;
  assign wr_ok   = acc && in_item.cmd == gibr_pkg::CmdWrite &&
                   {1'b0, in_item.col} < {2'b0, sw} && {1'b0, in_item.row} < {2'b0, sh};
  assign wr_bank = {in_item.row[0], in_item.col[0]};
  assign wr_addr = {in_item.row[7:1], in_item.col[7:1]};

  // Write delay line: a write reaches the banks at the depth of a read
  logic        wd_vld_r  [WD];
  logic [1:0]  wd_bank_r [WD];
  logic [13:0] wd_addr_r [WD];
  logic [7:0]  wd_pix_r  [WD];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WD; k++) wd_vld_r[k] <= 1'b0;
    end else begin
      wd_vld_r[0] <= wr_ok;
      for (int k = 1; k < WD; k++) wd_vld_r[k] <= wd_vld_r[k-1];
    end
    wd_bank_r[0] <= wr_bank;
    wd_addr_r[0] <= wr_addr;
    wd_pix_r[0]  <= in_item.pixel_in;
    for (int k = 1; k < WD; k++) begin
      wd_bank_r[k] <= wd_bank_r[k-1];
      wd_addr_r[k] <= wd_addr_r[k-1];
      wd_pix_r[k]  <= wd_pix_r[k-1];
    end
  end

  // Stage 1: multiply by source size, register
  logic          s1_vld_r, s1_oor_r;
  logic [PW-1:0] s1_nx_r, s1_ny_r;
  logic [10:0]   s1_dw_r, s1_dh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= acc && in_item.cmd == gibr_pkg::CmdRead;
    s1_oor_r <= {1'b0, in_item.col} >= dw || {1'b0, in_item.row} >= dh;
    s1_nx_r  <= PW'(in_item.col * sw);
    s1_ny_r  <= PW'(in_item.row * sh);
    s1_dw_r  <= dw;
    s1_dh_r  <= dh;
  end

  // Two divider pipelines; each carries its source size tag, the x one also the range flag
  logic                          dx_vld, dy_vld;
  logic [gibr_pkg::NumSteps-1:0] dx_quo, dy_quo;
  logic [19:0]                   dx_tag, dy_tag;
  gibr_div u_divx (.clk, .rst_n, .in_vld(s1_vld_r), .in_num({s1_nx_r, 8'd0}),
    .in_den(s1_dw_r), .in_tag({1'b0, s1_oor_r, 9'd0, sw}), .out_vld(dx_vld),
    .out_quo(dx_quo), .out_tag(dx_tag));
  gibr_div u_divy (.clk, .rst_n, .in_vld(s1_vld_r), .in_num({s1_ny_r, 8'd0}),
    .in_den(s1_dh_r), .in_tag({11'd0, sh}), .out_vld(dy_vld),
    .out_quo(dy_quo), .out_tag(dy_tag));

  // Stage D+1: neighbour coordinates with clamping
  logic          s2_vld_r, s2_oor_r;
  logic [7:0]    s2_p_r, s2_q_r;
  logic [8:0]    s2_x1_r, s2_x2_r, s2_y1_r, s2_y2_r;
  logic [PW-1:0] ix, iy;
  logic [8:0]    x1, y1, xsw, ysh;
  assign ix  = dx_quo[gibr_pkg::NumSteps-1:gibr_pkg::FracBits];
  assign iy  = dy_quo[gibr_pkg::NumSteps-1:gibr_pkg::FracBits];
  assign xsw = dx_tag[8:0];
  assign ysh = dy_tag[8:0];
  always_comb begin
    x1 = (ix > PW'(xsw - 9'd1)) ? xsw - 9'd1 : ix[8:0];
    y1 = (iy > PW'(ysh - 9'd1)) ? ysh - 9'd1 : iy[8:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= dx_vld && dy_vld;
    s2_oor_r <= dx_tag[18];
    s2_p_r   <= dx_quo[7:0];
    s2_q_r   <= dy_quo[7:0];
    s2_x1_r  <= x1;
    s2_y1_r  <= y1;
    s2_x2_r  <= (x1 + 9'd1 < xsw) ? x1 + 9'd1 : xsw - 9'd1;
    s2_y2_r  <= (y1 + 9'd1 < ysh) ? y1 + 9'd1 : ysh - 9'd1;
  end

  // Bank address for each bank: rows/cols of matching parity
  logic [13:0] rd_addr [4];
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_addr[b][13:7] = (s2_y1_r[0] == b[1]) ? s2_y1_r[7:1] : s2_y2_r[7:1];
      rd_addr[b][6:0]  = (s2_x1_r[0] == b[0]) ? s2_x1_r[7:1] : s2_x2_r[7:1];
    end
  end

  // Stage D+2: bank reads, delayed writes on the same clock
  logic [7:0] rd_r [4];
  logic       s3_vld_r, s3_oor_r;
  logic [7:0] s3_p_r, s3_q_r;
  logic       s3_xa_r, s3_xb_r, s3_ya_r, s3_yb_r;
  for (genvar b = 0; b < 4; b++) begin : g_bank
    always_ff @(posedge clk) begin
      if (wd_vld_r[WD-1] && wd_bank_r[WD-1] == 2'(b))
        bank[b][wd_addr_r[WD-1]] <= wd_pix_r[WD-1];
      rd_r[b] <= bank[b][rd_addr[b]];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_oor_r <= s2_oor_r;
    s3_p_r <= s2_p_r; s3_q_r <= s2_q_r;
    s3_xa_r <= s2_x1_r[0]; s3_xb_r <= s2_x2_r[0];
    s3_ya_r <= s2_y1_r[0]; s3_yb_r <= s2_y2_r[0];
  end

  // Stage D+3: horizontal blend of top and bottom rows
  logic [7:0]  pa, pb, pc, pd;
  logic [8:0]  wp;
  logic [16:0] h_top_r, h_bot_r;
  logic        s4_vld_r, s4_oor_r;
  logic [7:0]  s4_q_r;
  always_comb begin
    pa = rd_r[{s3_ya_r, s3_xa_r}];
    pb = rd_r[{s3_ya_r, s3_xb_r}];
    pc = rd_r[{s3_yb_r, s3_xa_r}];
    pd = rd_r[{s3_yb_r, s3_xb_r}];
    wp = 9'd256 - {1'b0, s3_p_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
    s4_oor_r <= s3_oor_r;
    s4_q_r   <= s3_q_r;
    h_top_r  <= 17'(wp * pa) + 17'(s3_p_r * pb);
    h_bot_r  <= 17'(wp * pc) + 17'(s3_p_r * pd);
  end

  // Stage D+4: vertical blend, truncate and saturate, output register
  logic [8:0]  wq;
  logic [25:0] vsum;
  assign wq   = 9'd256 - {1'b0, s4_q_r};
  assign vsum = 26'(wq * h_top_r) + 26'(s4_q_r * h_bot_r);
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= s4_vld_r;
    out_item.out_of_range <= s4_oor_r;
    out_item.pixel_out    <= s4_oor_r ? 8'd0 :
                             (vsum[25:16] > 10'd255) ? 8'd255 : vsum[23:16];
  end
endmodule
